[rtl/core/dfbf_pkg.sv]
// shared types, codes and constants for the delimited frame byte fifo
// no dependencies; imported by dfbf_ram and delimited_frame_byte_fifo_top
package dfbf_pkg;

    // default storage depth and the hard ceiling on one frame's length
    localparam int DEPTH_DEF = 256;
    localparam int MAX_FRAME = 32;

    // field and register widths
    localparam int BYTE_W    = 8;
    localparam int CAP_W     = 9;
    localparam int LIM_W     = 6;
    localparam int MAXF_W    = 9;
    localparam int FILL_W    = 9;
    localparam int TOTAL_W   = 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    // register reset values
    localparam int CAP_RST   = 256;
    localparam int DELIM_RST = 126;
    localparam int LIM_RST   = 32;
    localparam int MAXF_RST  = 256;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_FRAME = 2'd2,
        FUNC_QUERY = 2'd3
    } func_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_BAD_FRAME = 2'd3
    } status_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RING_CAP    = 2'd0,
        CFG_DELIM       = 2'd1,
        CFG_FRAME_LIMIT = 2'd2,
        CFG_MAX_FRAMES  = 2'd3
    } cfg_idx_t;

    // control sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_FRAME,
        S_QUERY
    } state_t;

    // request word
    typedef struct packed {
        func_t             func;
        logic [BYTE_W-1:0] in_byte;
    } req_word_t;

    // response word
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        status_t            status;
        logic               last;
        logic [FILL_W-1:0]  fill_level;
        logic [TOTAL_W-1:0] frame_total;
        logic               can_accept;
    } rsp_word_t;

endpackage

[rtl/core/dfbf_ram.sv]
// generic single write port, single read port ram with registered read data
// depends on dfbf_pkg for default sizes
module dfbf_ram #(
    parameter int WIDTH = dfbf_pkg::BYTE_W,
    parameter int DEPTH = dfbf_pkg::DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    import dfbf_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/delimited_frame_byte_fifo_top.sv]
// top level of the delimited frame byte fifo: sequencer, pointers and response register
// depends on dfbf_pkg and dfbf_ram

// A byte ring buffer held in one synchronous ram, with ring_capacity entries in
// use, driven by request words that write a byte, read a byte, read a frame or
// query status. Every request is taken in the idle state and then executed: a
// byte write or byte read runs in its own state, which registers its response
// word. A frame read walks the buffer one byte per cycle through the ram read
// port, unless a stalled response holds it, and consumes every byte it walks
// (dropped leading bytes included); it also ends on an empty buffer or a zero
// frame limit. A status query scans every stored byte, one per cycle. A stalled
// response holds the sequencer in any step that emits a response word; request
// stall is high whenever the sequencer is busy. The ram needs no clearing after
// reset: only stored bytes are ever read. Writing ring_capacity empties the
// buffer.
module delimited_frame_byte_fifo_top #(
    parameter int DEPTH = dfbf_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  dfbf_pkg::req_word_t         req_word,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output dfbf_pkg::rsp_word_t         rsp_word,
    input  logic                        cfg_we,
    input  dfbf_pkg::cfg_idx_t          cfg_index,
    input  logic [dfbf_pkg::CFG_W-1:0]  cfg_data
);
    import dfbf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_EFF_RST = (CAP_RST > DEPTH) ? DEPTH : CAP_RST;
    localparam int LIM_EFF_RST = (LIM_RST > MAX_FRAME) ? MAX_FRAME : LIM_RST;

    // sequencer and command
    state_t            state_reg, state_next;
    req_word_t         cmd_reg, cmd_next;

    // ring pointers and occupancy
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  count_after;

    // configuration, kept in effective form
    logic [CNT_W-1:0]  cap_eff_reg, cap_eff_next;
    logic [BYTE_W-1:0] delim_reg, delim_next;
    logic [LIM_W-1:0]  lim_reg, lim_next;
    logic [MAXF_W-1:0] maxf_reg, maxf_next;

    // frame read and query scan state
    logic [LIM_W-1:0]   fcnt_reg, fcnt_next;
    logic [PTR_W-1:0]   scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0]   remain_reg, remain_next;
    logic               inside_reg, inside_next;
    logic               pnz_reg, pnz_next;
    logic [TOTAL_W-1:0] frames_reg, frames_next;

    // response register
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_word_t         rsp_word_reg, rsp_word_next;

    // step control
    logic              accept;
    logic              out_free;
    logic              step_emit, step_pop, step_push, step_done, step_scan, step_go;
    rsp_word_t         emit_word;
    logic              can_acc;

    // ram side
    logic [PTR_W-1:0]  ram_raddr;
    logic [BYTE_W-1:0] head_byte;
    logic              head_is_delim;
    logic              ram_we;

    // next pointer position, wrapping at the capacity in use
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] n;
        begin
            n = CNT_W'(p) + CNT_W'(1);
            advance = (n >= cap) ? '0 : PTR_W'(n);
        end
    endfunction

    // byte store
    dfbf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (cmd_reg.in_byte),
        .raddr (ram_raddr),
        .rdata (head_byte)
    );

    assign accept        = req_valid && !req_stall;
    assign out_free      = !rsp_valid_reg || !rsp_stall;
    assign head_is_delim = (head_byte == delim_reg);
    assign can_acc       = ({1'b0, frames_reg} < maxf_reg) &&
                           ((32'(count_reg) + 32'(lim_reg)) <= 32'(cap_eff_reg));

    // what the current state does this cycle
    always_comb
    begin
        step_emit = 1'b0;
        step_pop  = 1'b0;
        step_push = 1'b0;
        step_done = 1'b0;
        step_scan = 1'b0;
        emit_word = '0;
        emit_word.status = STAT_OK;
        emit_word.last   = 1'b1;
        unique case (state_reg)
            S_WRITE:
            begin
                step_emit = 1'b1;
                step_done = 1'b1;
                if (count_reg < cap_eff_reg)
                begin
                    step_push = 1'b1;
                end
                else
                begin
                    emit_word.status = STAT_FULL;
                end
            end
            S_READ:
            begin
                step_emit = 1'b1;
                step_done = 1'b1;
                if (count_reg != '0)
                begin
                    step_pop           = 1'b1;
                    emit_word.out_byte = head_byte;
                end
                else
                begin
                    emit_word.status = STAT_EMPTY;
                end
            end
            S_FRAME:
            begin
                if ((lim_reg == '0) || (count_reg == '0))
                begin
                    // zero limit or buffer ran dry
                    step_emit        = 1'b1;
                    step_done        = 1'b1;
                    emit_word.status = STAT_BAD_FRAME;
                end
                else if (fcnt_reg == '0)
                begin
                    // hunting for the opening delimiter
                    step_pop = 1'b1;
                    if (head_is_delim)
                    begin
                        step_emit          = 1'b1;
                        emit_word.out_byte = head_byte;
                        emit_word.last     = 1'b0;
                    end
                end
                else if (fcnt_reg >= lim_reg)
                begin
                    // frame overran its limit: the byte is consumed
                    step_pop         = 1'b1;
                    step_emit        = 1'b1;
                    step_done        = 1'b1;
                    emit_word.status = STAT_BAD_FRAME;
                end
                else
                begin
                    step_pop           = 1'b1;
                    step_emit          = 1'b1;
                    step_done          = head_is_delim;
                    emit_word.out_byte = head_byte;
                    emit_word.last     = head_is_delim;
                end
            end
            S_QUERY:
            begin
                if (remain_reg == '0)
                begin
                    step_emit             = 1'b1;
                    step_done             = 1'b1;
                    emit_word.frame_total = frames_reg;
                    emit_word.can_accept  = can_acc;
                end
                else
                begin
                    step_scan = 1'b1;
                end
            end
            default:
            begin
                step_emit = 1'b0;
            end
        endcase
        emit_word.fill_level = FILL_W'(count_reg + CNT_W'(step_push) - CNT_W'(step_pop));
    end

    assign step_go     = !step_emit || out_free;
    assign count_after = count_reg + CNT_W'(step_push) - CNT_W'(step_pop);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_word.func)
                        FUNC_WRITE: state_next = S_WRITE;
                        FUNC_READ:  state_next = S_READ;
                        FUNC_FRAME: state_next = S_FRAME;
                        FUNC_QUERY: state_next = S_QUERY;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_WRITE, S_READ, S_FRAME, S_QUERY:
            begin
                if (step_go && step_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req_stall = (state_reg != S_IDLE);
        ram_we    = step_go && step_push;
        ram_raddr = (state_reg == S_QUERY) ? scan_ptr_next : rd_ptr_next;
    end

    // datapath next values
    always_comb
    begin
        logic [31:0] cap_req;
        logic [LIM_W-1:0] lim_req;
        cap_req        = 32'(cfg_data[CAP_W-1:0]);
        lim_req        = cfg_data[LIM_W-1:0];
        cmd_next       = cmd_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        count_next     = count_reg;
        cap_eff_next   = cap_eff_reg;
        delim_next     = delim_reg;
        lim_next       = lim_reg;
        maxf_next      = maxf_reg;
        fcnt_next      = fcnt_reg;
        scan_ptr_next  = scan_ptr_reg;
        remain_next    = remain_reg;
        inside_next    = inside_reg;
        pnz_next       = pnz_reg;
        frames_next    = frames_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;

        // take a new request and prime the walkers
        if (accept)
        begin
            cmd_next      = req_word;
            scan_ptr_next = rd_ptr_reg;
            remain_next   = count_reg;
            inside_next   = 1'b0;
            pnz_next      = 1'b0;
            frames_next   = '0;
            fcnt_next     = '0;
        end

        // pointer and occupancy updates
        if (step_go)
        begin
            if (step_pop)
            begin
                rd_ptr_next = advance(rd_ptr_reg, cap_eff_reg);
            end
            if (step_push)
            begin
                wr_ptr_next = advance(wr_ptr_reg, cap_eff_reg);
            end
            count_next = count_after;
            if ((state_reg == S_FRAME) && step_pop && !step_done &&
                ((fcnt_reg != '0) || head_is_delim))
            begin
                fcnt_next = fcnt_reg + LIM_W'(1);
            end
        end

        // query scan over the stored bytes
        if (step_scan)
        begin
            scan_ptr_next = advance(scan_ptr_reg, cap_eff_reg);
            remain_next   = remain_reg - CNT_W'(1);
            if (head_is_delim)
            begin
                if (inside_reg && pnz_reg && (frames_reg != '1))
                begin
                    frames_next = frames_reg + TOTAL_W'(1);
                end
                inside_next = 1'b1;
                pnz_next    = 1'b0;
            end
            else if (inside_reg)
            begin
                pnz_next = 1'b1;
            end
        end

        // response register
        if (step_go && step_emit)
        begin
            rsp_valid_next = 1'b1;
            rsp_word_next  = emit_word;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RING_CAP:
                begin
                    if (cap_req == 32'd0)
                    begin
                        cap_eff_next = CNT_W'(1);
                    end
                    else if (cap_req > 32'(DEPTH))
                    begin
                        cap_eff_next = CNT_W'(DEPTH);
                    end
                    else
                    begin
                        cap_eff_next = CNT_W'(cap_req);
                    end
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                    count_next  = '0;
                end
                CFG_DELIM:
                begin
                    delim_next = cfg_data[BYTE_W-1:0];
                end
                CFG_FRAME_LIMIT:
                begin
                    lim_next = (lim_req > LIM_W'(MAX_FRAME)) ? LIM_W'(MAX_FRAME) : lim_req;
                end
                CFG_MAX_FRAMES:
                begin
                    maxf_next = cfg_data[MAXF_W-1:0];
                end
                default:
                begin
                    delim_next = delim_reg;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            cap_eff_reg   <= CNT_W'(CAP_EFF_RST);
            delim_reg     <= BYTE_W'(DELIM_RST);
            lim_reg       <= LIM_W'(LIM_EFF_RST);
            maxf_reg      <= MAXF_W'(MAXF_RST);
            fcnt_reg      <= '0;
            scan_ptr_reg  <= '0;
            remain_reg    <= '0;
            inside_reg    <= 1'b0;
            pnz_reg       <= 1'b0;
            frames_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            cap_eff_reg   <= cap_eff_next;
            delim_reg     <= delim_next;
            lim_reg       <= lim_next;
            maxf_reg      <= maxf_next;
            fcnt_reg      <= fcnt_next;
            scan_ptr_reg  <= scan_ptr_next;
            remain_reg    <= remain_next;
            inside_reg    <= inside_next;
            pnz_reg       <= pnz_next;
            frames_reg    <= frames_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

`ifndef ASSERT_OFF
    // occupancy never exceeds the capacity in use
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_eff_reg)
        else $error("stored count above capacity");

    // both pointers stay inside the ring
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(rd_ptr_reg) < cap_eff_reg) && (CNT_W'(wr_ptr_reg) < cap_eff_reg))
        else $error("ring pointer outside capacity");

    // empty or full ring has coincident pointers
    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        ((count_reg == '0) || (count_reg == cap_eff_reg)) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("pointers disagree with occupancy");

    // frame byte count never passes the limit while a frame is walked
    a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FRAME) |-> (fcnt_reg <= lim_reg))
        else $error("frame byte count above limit");

    // a query never scans more bytes than are stored
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QUERY) |-> (remain_reg <= count_reg))
        else $error("query scan beyond stored bytes");
`endif

endmodule
